@@ design/svb_pkg.sv @@
// shared constants, register indexes and state codes of the semivariogram binner
`timescale 1ns / 1ps
package svb_pkg;

    localparam int MAX_LAGS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 24;

    localparam int DIST_W   = 32;
    localparam int ANGLE_W  = 17;
    localparam int TOL_W    = 14;
    localparam int LAGCFG_W = 5;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 2;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 64;
    localparam int IDX_W    = 4;
    localparam int SEMI_W   = 49;

    localparam logic [CFG_AW-1:0] REG_LAG_INCREMENT   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_LAG_COUNT       = 2'd1;
    localparam logic [CFG_AW-1:0] REG_ANGLE_DIRECTION = 2'd2;
    localparam logic [CFG_AW-1:0] REG_ANGLE_TOLERANCE = 2'd3;

    localparam logic [TOL_W-1:0] TOL_OMNI    = 14'd9000;
    localparam logic [DIST_W-1:0] INC_RESET  = 32'd65536;
    localparam logic [LAGCFG_W-1:0] LAGS_RESET = 5'd16;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQUARE = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_UPDATE = 7'b0001000,
        ST_LOAD   = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

endpackage

@@ design/empirical_semivariogram_binner.sv @@
// top level of the empirical semivariogram binner: lag search, bins and shared divider
`timescale 1ns / 1ps
//
// channel   dir  tdata fields (lsb first)                                      tlast
// s_        in   pair_distance, pair_angle, value_first, value_second          last_pair
// m_        out  lag_index, mean_distance, semivariance, bin_pairs             last_lag
// cfg_      in   write enable, register index, write data                      -
//
// a pair item whose direction is rejected is dropped without a search; otherwise it
// passes the squaring state, then the lag search walks the n classes in use one per cycle,
// then the bin update on a hit; the last pair then emits n results, each through one load,
// 64 steps for the mean and 64 for the semivariance in the shared one-bit-a-step
// divider (skipped for an empty bin), then the output stage
// reset restores the configuration and control registers and clears every bin at once through per-bin valid bits
// a stalled result holds in the output register; no item is taken until it goes
module empirical_semivariogram_binner
    import svb_pkg::*;
#(
    parameter int MAX_LAGS   = MAX_LAGS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // pair_distance, pair_angle, value_first, value_second
    input  logic [((DIST_W+ANGLE_W+2*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // lag_index, mean_distance, semivariance, bin_pairs
    output logic [((IDX_W+DIST_W+SEMI_W+CNT_W+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,
    input  logic cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int MW    = ((IDX_W+DIST_W+SEMI_W+CNT_W+7)/8)*8;
    localparam int KW    = $clog2(MAX_LAGS+1);
    localparam int AW    = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
    localparam int BW    = DIST_W + $clog2(2*MAX_LAGS+4);
    localparam int DW    = VALUE_BITS + 1;
    localparam int QW    = 2*DW;
    localparam int RW    = CNT_W + 2;
    localparam int STEPW = $clog2(SUM_W);
    localparam int AngW  = ANGLE_W + 2;

    // configuration registers
    logic [DIST_W-1:0]   inc_reg;
    logic [LAGCFG_W-1:0] lags_reg;
    logic signed [ANGLE_W-1:0] dir_reg;
    logic [TOL_W-1:0]    tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg  <= INC_RESET;
            lags_reg <= LAGS_RESET;
            dir_reg  <= '0;
            tol_reg  <= TOL_OMNI;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LAG_INCREMENT:   inc_reg  <= cfg_wdata[DIST_W-1:0];
                REG_LAG_COUNT:       lags_reg <= cfg_wdata[LAGCFG_W-1:0];
                REG_ANGLE_DIRECTION: dir_reg  <= signed'(cfg_wdata[ANGLE_W-1:0]);
                REG_ANGLE_TOLERANCE: tol_reg  <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // lags in use, clamped to 1..MAX_LAGS
    logic [KW-1:0] n_lags;
    always_comb begin
        if (lags_reg == '0)
            n_lags = KW'(1);
        else if (32'(lags_reg) > 32'(MAX_LAGS))
            n_lags = KW'(MAX_LAGS);
        else
            n_lags = KW'(lags_reg);
    end

    // input field split
    logic [DIST_W-1:0] in_dist;
    logic signed [ANGLE_W-1:0] in_angle;
    logic signed [VALUE_BITS-1:0] in_va, in_vb;
    assign in_dist  = s_tdata[DIST_W-1:0];
    assign in_angle = signed'(s_tdata[DIST_W +: ANGLE_W]);
    assign in_va    = signed'(s_tdata[DIST_W+ANGLE_W +: VALUE_BITS]);
    assign in_vb    = signed'(s_tdata[DIST_W+ANGLE_W+VALUE_BITS +: VALUE_BITS]);

    // direction window, no wrap
    logic signed [AngW-1:0] ang_lo, ang_hi, ang_x;
    logic angle_ok;
    always_comb begin
        ang_x    = AngW'(in_angle);
        ang_lo   = AngW'(dir_reg) - signed'(AngW'({1'b0, tol_reg}));
        ang_hi   = AngW'(dir_reg) + signed'(AngW'({1'b0, tol_reg}));
        angle_ok = (tol_reg == TOL_OMNI) || ((ang_x >= ang_lo) && (ang_x <= ang_hi));
    end

    // bins
    logic [CNT_W-1:0] bcnt_reg  [MAX_LAGS];
    logic [SUM_W-1:0] bdsum_reg [MAX_LAGS];
    logic [SUM_W-1:0] bssum_reg [MAX_LAGS];
    logic [MAX_LAGS-1:0] bvalid_reg, bvalid_next;

    state_t state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [DW-1:0] diff_reg, diff_next;
    logic [DW-1:0] abs_diff;
    logic [QW-1:0] sq_reg, sq_next;
    logic last_reg, last_next;
    logic [BW-1:0] bound_reg, bound_next;

    // divider
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [STEPW-1:0] step_reg, step_next;
    logic sel_reg, sel_next;
    logic [CNT_W-1:0] ccnt_reg, ccnt_next;
    logic [SUM_W-1:0] csq_reg, csq_next;

    logic [MW-1:0] mdata_reg, mdata_next;
    logic mvalid_reg, mvalid_next, mlast_reg, mlast_next;
    logic [DIST_W-1:0] mean_reg, mean_next;

    logic [AW-1:0] k_a;
    logic [CNT_W-1:0] rd_cnt;
    logic [SUM_W-1:0] rd_dsum, rd_ssum;
    logic [BW:0] d2, upper;
    logic hit;
    logic [CNT_W:0] cnt_inc;
    logic [SUM_W:0] dsum_add, ssum_add;
    logic [RW-1:0] rem_sh, divisor;
    logic q_bit;
    logic [SEMI_W-1:0] semi_sat;
    logic wr_en;

    assign k_a     = k_reg[AW-1:0];
    assign rd_cnt  = bvalid_reg[k_a] ? bcnt_reg[k_a]  : '0;
    assign rd_dsum = bvalid_reg[k_a] ? bdsum_reg[k_a] : '0;
    assign rd_ssum = bvalid_reg[k_a] ? bssum_reg[k_a] : '0;

    // magnitude of the value difference, at its own width
    assign abs_diff = diff_reg[DW-1] ? -diff_reg : diff_reg;

    // one class bound check per cycle
    always_comb begin
        d2    = (BW+1)'({dist_reg, 1'b0});
        upper = (k_reg == '0) ? (BW+1)'(bound_reg)
                              : (BW+1)'(bound_reg) + (BW+1)'({inc_reg, 1'b0});
        if (k_reg == '0)
            hit = (dist_reg != '0) && (d2 <= upper);
        else
            hit = (d2 > (BW+1)'(bound_reg)) && (d2 <= upper);
    end

    // saturating bin update
    always_comb begin
        cnt_inc  = (CNT_W+1)'(rd_cnt) + (CNT_W+1)'(1);
        dsum_add = (SUM_W+1)'(rd_dsum) + (SUM_W+1)'(dist_reg);
        ssum_add = (SUM_W+1)'(rd_ssum) + (SUM_W+1)'(sq_reg);
    end

    // restoring divider step
    always_comb begin
        rem_sh  = {rem_reg[RW-2:0], dvd_reg[SUM_W-1]};
        divisor = sel_reg ? RW'({ccnt_reg, 1'b0}) : RW'(ccnt_reg);
        q_bit   = (rem_sh >= divisor);
    end

    assign semi_sat = (dvd_next[SUM_W-1:SEMI_W] != '0) ? '1 : dvd_next[SEMI_W-1:0];

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        dist_next   = dist_reg;
        diff_next   = diff_reg;
        sq_next     = sq_reg;
        last_next   = last_reg;
        bound_next  = bound_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        sel_next    = sel_reg;
        ccnt_next   = ccnt_reg;
        csq_next    = csq_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg;
        mlast_next  = mlast_reg;
        mean_next   = mean_reg;
        bvalid_next = bvalid_reg;
        wr_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    dist_next  = in_dist;
                    diff_next  = DW'(in_va) - DW'(in_vb);
                    last_next  = s_tlast;
                    k_next     = '0;
                    bound_next = BW'(inc_reg);
                    if (angle_ok)
                        state_next = ST_SQUARE;
                    else
                        state_next = s_tlast ? ST_LOAD : ST_IDLE;
                end
            end
            ST_SQUARE: begin
                // absolute difference squared
                sq_next    = QW'(abs_diff) * QW'(abs_diff);
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (hit) begin
                    state_next = ST_UPDATE;
                end else if (k_reg + KW'(1) >= n_lags) begin
                    k_next     = '0;
                    state_next = last_reg ? ST_LOAD : ST_IDLE;
                end else begin
                    // lower bound of the next class, (2k+1) increments doubled
                    k_next     = k_reg + KW'(1);
                    bound_next = bound_reg + BW'({inc_reg, 1'b0});
                end
            end
            ST_UPDATE: begin
                wr_en               = 1'b1;
                bvalid_next[k_a]    = 1'b1;
                k_next              = '0;
                state_next          = last_reg ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                ccnt_next = rd_cnt;
                csq_next  = rd_ssum;
                dvd_next  = rd_dsum;
                rem_next  = '0;
                step_next = '0;
                sel_next  = 1'b0;
                if (rd_cnt == '0) begin
                    mean_next  = '0;
                    dvd_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? rem_sh - divisor : rem_sh;
                dvd_next  = {dvd_reg[SUM_W-2:0], q_bit};
                step_next = step_reg + STEPW'(1);
                if (step_reg == '1) begin
                    if (!sel_reg) begin
                        // mean done, start the semivariance
                        mean_next = (dvd_next[SUM_W-1:DIST_W] != '0) ? '1
                                                                     : dvd_next[DIST_W-1:0];
                        dvd_next  = csq_reg;
                        rem_next  = '0;
                        sel_next  = 1'b1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!mvalid_reg) begin
                    mdata_next  = MW'({ccnt_reg,
                                       (sel_reg ? semi_sat : SEMI_W'(0)),
                                       mean_reg,
                                       IDX_W'(k_reg)});
                    mlast_next  = (k_reg + KW'(1) == n_lags);
                    mvalid_next = 1'b1;
                end else if (m_tready) begin
                    mvalid_next = 1'b0;
                    if (mlast_reg) begin
                        bvalid_next = '0;
                        k_next      = '0;
                        state_next  = ST_IDLE;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            k_reg      <= '0;
            bvalid_reg <= '0;
            mvalid_reg <= 1'b0;
            mlast_reg  <= 1'b0;
            step_reg   <= '0;
            sel_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            bvalid_reg <= bvalid_next;
            mvalid_reg <= mvalid_next;
            mlast_reg  <= mlast_next;
            step_reg   <= step_next;
            sel_reg    <= sel_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg  <= dist_next;
        diff_reg  <= diff_next;
        sq_reg    <= sq_next;
        bound_reg <= bound_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        ccnt_reg  <= ccnt_next;
        csq_reg   <= csq_next;
        mdata_reg <= mdata_next;
        mean_reg  <= mean_next;
        if (wr_en) begin
            bcnt_reg[k_a]  <= cnt_inc[CNT_W] ? rd_cnt : cnt_inc[CNT_W-1:0];
            bdsum_reg[k_a] <= dsum_add[SUM_W] ? '1 : dsum_add[SUM_W-1:0];
            bssum_reg[k_a] <= ssum_add[SUM_W] ? '1 : ssum_add[SUM_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule
